// ----- hdl/content_to_regex_escaper_defines.svh -----
// ----------------------------------------------------------------------------
// Regex escaper assertion macros
// Shared assertion forms for the regex escaper checkers.
// ----------------------------------------------------------------------------
`ifndef CONTENT_TO_REGEX_ESCAPER_DEFINES_SVH
`define CONTENT_TO_REGEX_ESCAPER_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define CTRE_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("regex escaper check failed");

// Next-cycle implication, masked while reset is high
`define CTRE_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("regex escaper check failed");

// Next-cycle implication, also checked across reset
`define CTRE_ASSERT_NXT_ALWAYS(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("regex escaper check failed");

`endif

// ----- hdl/ctre_pkg.sv -----
// ----------------------------------------------------------------------------
// Regex escaper package
// Types, codes, character constants and helper functions of the escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package ctre_pkg;

   // Pattern length limit used by the option checks
   localparam logic [12:0] MAX_PATTERN = 13'd4096;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_OPTION_FLAGS   = 3'd0;
   localparam logic [2:0] REG_OFFSET_VALUE   = 3'd1;
   localparam logic [2:0] REG_DEPTH_VALUE    = 3'd2;
   localparam logic [2:0] REG_DISTANCE_VALUE = 3'd3;
   localparam logic [2:0] REG_WITHIN_VALUE   = 3'd4;
   localparam logic [2:0] REG_PATTERN_LENGTH = 3'd5;

   // Option flag bit positions
   localparam int FLAG_OFFSET   = 0;
   localparam int FLAG_DEPTH    = 1;
   localparam int FLAG_DISTANCE = 2;
   localparam int FLAG_WITHIN   = 3;
   localparam int FLAG_NOCASE   = 4;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_COMBO = 2'd1;
   localparam logic [1:0] ST_NEG_DIST  = 2'd2;

   // Byte escape classes
   localparam logic [1:0] ESC_PASS = 2'd0;
   localparam logic [1:0] ESC_BSL  = 2'd1;
   localparam logic [1:0] ESC_HEX  = 2'd2;

   // Characters of the regex text
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // Job queue depth between front and back
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // Decimal digit positions, most significant first
   localparam logic [2:0] DIGIT_POS_FIRST = 3'd0;
   localparam logic [2:0] DIGIT_POS_LAST  = 3'd4;

   typedef struct packed {
      logic [7:0] content_byte;
      logic       is_final_byte;
   } ctre_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] status;
      logic       end_of_text;
   } ctre_rsp_type;

   typedef struct packed {
      logic [4:0]  option_flags;
      logic [15:0] offset_value;
      logic [15:0] depth_value;
      logic [15:0] distance_value;
      logic [15:0] within_value;
      logic [12:0] pattern_length;
   } ctre_cfg_type;

   // One classified pattern byte, handed from front to back
   typedef struct packed {
      logic [1:0]  err;
      logic        hdr;
      logic        caret;
      logic        range;
      logic        max_digits;
      logic [15:0] min_skip;
      logic [15:0] max_skip;
      logic [7:0]  content_byte;
      logic [1:0]  esc_class;
      logic        fin;
      logic        nocase;
      logic        relative;
   } ctre_job_type;

   typedef struct packed {
      logic [3:0]  digit;
      logic [15:0] rem;
   } ctre_digit_type;

   // Escape class of a raw byte
   function automatic logic [1:0] ctre_esc_class(input logic [7:0] b);
      logic [1:0] c;
      case (b) inside
         [8'h00:8'h1F], [8'h7F:8'hFF]: c = ESC_HEX;
         8'h24, [8'h28:8'h2E], 8'h3F, [8'h5B:8'h5E], [8'h7B:8'h7D]: c = ESC_BSL;
         default: c = ESC_PASS;
      endcase
      return c;
   endfunction

   // Uppercase hex character of a nibble
   function automatic logic [7:0] ctre_hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = CH_ZERO + {4'd0, n};
      end else begin
         c = CH_A + {4'd0, n} - 8'd10;
      end
      return c;
   endfunction

   // One decimal digit at a given position, with the remainder below it
   function automatic ctre_digit_type ctre_digit_step(input logic [15:0] v,
                                                      input logic [2:0] pos);
      logic [16:0]    p;
      logic [16:0]    t;
      ctre_digit_type r;
      case (pos)
         3'd0:    p = 17'd10000;
         3'd1:    p = 17'd1000;
         3'd2:    p = 17'd100;
         3'd3:    p = 17'd10;
         default: p = 17'd1;
      endcase
      r.digit = 4'd0;
      r.rem   = v;
      for (int k = 1; k < 10; k++) begin
         t = 17'(p * 17'(k));
         if ({1'b0, v} >= t) begin
            r.digit = 4'(k);
            r.rem   = 16'({1'b0, v} - t);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ctre_front.sv -----
// ----------------------------------------------------------------------------
// Regex escaper front end
// Accepts pattern bytes, checks options on the first byte and classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module ctre_front import ctre_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctre_cfg_type cfg,
   input  wire logic         req_push,
   input  wire ctre_req_type req_data,
   output logic              req_full,
   output logic              job_push,
   output ctre_job_type      job_data,
   input  wire logic         job_full
);

   logic        header_sent_ff, header_sent_in;
   logic        error_latched_ff, error_latched_in;
   logic        accept;
   logic [12:0] len;
   logic [14:0] len15;
   logic        f_off, f_depth, f_dist, f_within;
   logic        depth_short, within_short;
   logic [1:0]  err;
   logic [14:0] min15;
   logic        has_max;
   logic [14:0] max_base;
   logic [15:0] max_skip;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   // Saturate the pattern length
   assign len   = (cfg.pattern_length > MAX_PATTERN) ? MAX_PATTERN : cfg.pattern_length;
   assign len15 = {2'd0, len};

   assign f_off    = cfg.option_flags[FLAG_OFFSET];
   assign f_depth  = cfg.option_flags[FLAG_DEPTH];
   assign f_dist   = cfg.option_flags[FLAG_DISTANCE];
   assign f_within = cfg.option_flags[FLAG_WITHIN];

   assign depth_short  = cfg.depth_value[15] || (cfg.depth_value[14:0] < len15);
   assign within_short = cfg.within_value[15] || (cfg.within_value[14:0] < len15);

   // Check option combination in priority order
   always_comb begin
      if (f_off && (f_dist || cfg.offset_value[15])) begin
         err = ST_BAD_COMBO;
      end else if (f_dist && cfg.distance_value[15]) begin
         err = ST_NEG_DIST;
      end else if (f_depth && (f_within || depth_short)) begin
         err = ST_BAD_COMBO;
      end else if (f_within && within_short) begin
         err = ST_BAD_COMBO;
      end else begin
         err = ST_OK;
      end
   end

   // Derive the skip window
   always_comb begin
      if (f_dist) begin
         min15 = cfg.distance_value[14:0];
      end else if (f_off) begin
         min15 = cfg.offset_value[14:0];
      end else begin
         min15 = 15'd0;
      end
      has_max = f_within || f_depth;
      if (f_within) begin
         max_base = cfg.within_value[14:0] - len15;
      end else begin
         max_base = cfg.depth_value[14:0] - len15;
      end
      if (min15 != 15'd0 && has_max) begin
         max_skip = {1'b0, max_base} + {1'b0, min15};
      end else begin
         max_skip = {1'b0, max_base};
      end
   end

   // Build the job for the back end
   always_comb begin
      job_data.err          = header_sent_ff ? ST_OK : err;
      job_data.hdr          = !header_sent_ff;
      job_data.caret        = (min15 != 15'd0) || has_max;
      job_data.range        = job_data.caret && (!has_max || max_skip != 16'd0);
      job_data.max_digits   = has_max && max_skip != 16'd0;
      job_data.min_skip     = {1'b0, min15};
      job_data.max_skip     = max_skip;
      job_data.content_byte = req_data.content_byte;
      job_data.esc_class    = ctre_esc_class(req_data.content_byte);
      job_data.fin          = req_data.is_final_byte;
      job_data.nocase       = cfg.option_flags[FLAG_NOCASE];
      job_data.relative     = f_dist || f_within;
   end

   // Drop bytes of a rejected pattern, track the header
   always_comb begin
      job_push         = 1'b0;
      header_sent_in   = header_sent_ff;
      error_latched_in = error_latched_ff;
      if (accept) begin
         if (error_latched_ff) begin
            if (req_data.is_final_byte) begin
               error_latched_in = 1'b0;
            end
         end else begin
            job_push = 1'b1;
            if (!header_sent_ff && err != ST_OK) begin
               error_latched_in = !req_data.is_final_byte;
            end else begin
               header_sent_in = !req_data.is_final_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_sent_ff   <= 1'b0;
         error_latched_ff <= 1'b0;
      end else begin
         header_sent_ff   <= header_sent_in;
         error_latched_ff <= error_latched_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ctre_job_queue.sv -----
// ----------------------------------------------------------------------------
// Regex escaper job queue
// Short queue of classified bytes between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctre_job_queue import ctre_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire ctre_job_type push_job,
   output logic              full,
   input  wire logic         pop,
   output ctre_job_type      head_job,
   output logic              empty
);

   ctre_job_type               entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]       count_ff, count_in;
   logic                       do_push, do_pop;

   assign full     = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ctre_back.sv -----
// ----------------------------------------------------------------------------
// Regex escaper back end
// Sequences the characters of each job into a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ctre_back import ctre_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctre_job_type head_job,
   input  wire logic         job_empty,
   output logic              job_pop,
   output logic              rsp_empty,
   output ctre_rsp_type      rsp_data,
   input  wire logic         rsp_pop
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_ERR     = 5'd1;
   localparam logic [4:0] S_HQUOTE  = 5'd2;
   localparam logic [4:0] S_HSLASH  = 5'd3;
   localparam logic [4:0] S_CARET   = 5'd4;
   localparam logic [4:0] S_DOT     = 5'd5;
   localparam logic [4:0] S_LBRACE  = 5'd6;
   localparam logic [4:0] S_MIN     = 5'd7;
   localparam logic [4:0] S_COMMA   = 5'd8;
   localparam logic [4:0] S_MAX     = 5'd9;
   localparam logic [4:0] S_RBRACE  = 5'd10;
   localparam logic [4:0] S_BSL     = 5'd11;
   localparam logic [4:0] S_HEXX    = 5'd12;
   localparam logic [4:0] S_HEXHI   = 5'd13;
   localparam logic [4:0] S_HEXLO   = 5'd14;
   localparam logic [4:0] S_BYTE    = 5'd15;
   localparam logic [4:0] S_TSLASH  = 5'd16;
   localparam logic [4:0] S_TS      = 5'd17;
   localparam logic [4:0] S_TI      = 5'd18;
   localparam logic [4:0] S_TR      = 5'd19;
   localparam logic [4:0] S_TQUOTE  = 5'd20;

   logic [4:0]     state_ff, state_in, state_next;
   ctre_job_type   job_ff, job_in;
   logic [15:0]    dv_ff, dv_in;
   logic [2:0]     pos_ff, pos_in;
   logic           started_ff, started_in;
   ctre_digit_type dstep;
   logic           in_digits, digit_last;
   logic           out_space, adv;
   logic           emit;
   ctre_rsp_type   emit_data;

   ctre_rsp_type   out_ff [2];
   logic           out_wr_ff, out_rd_ff;
   logic [1:0]     out_cnt_ff, out_cnt_in;
   logic           out_pop;

   // First state of the body of a job
   function automatic logic [4:0] body_first(input ctre_job_type j);
      return (j.esc_class == ESC_PASS) ? S_BYTE : S_BSL;
   endfunction

   // First state of a job
   function automatic logic [4:0] job_first(input ctre_job_type j);
      logic [4:0] s;
      if (j.err != ST_OK) begin
         s = S_ERR;
      end else if (j.hdr) begin
         s = S_HQUOTE;
      end else begin
         s = body_first(j);
      end
      return s;
   endfunction

   assign out_space  = (out_cnt_ff != 2'd2);
   assign adv        = (state_ff != S_IDLE) && out_space;
   assign in_digits  = (state_ff == S_MIN) || (state_ff == S_MAX);
   assign digit_last = (pos_ff == DIGIT_POS_LAST);
   assign dstep      = ctre_digit_step(dv_ff, pos_ff);

   // Step to the next character of the job
   always_comb begin
      case (state_ff)
         S_ERR:    state_next = S_IDLE;
         S_HQUOTE: state_next = S_HSLASH;
         S_HSLASH: state_next = job_ff.caret ? S_CARET : body_first(job_ff);
         S_CARET:  state_next = job_ff.range ? S_DOT : body_first(job_ff);
         S_DOT:    state_next = S_LBRACE;
         S_LBRACE: state_next = S_MIN;
         S_MIN:    state_next = digit_last ? S_COMMA : S_MIN;
         S_COMMA:  state_next = job_ff.max_digits ? S_MAX : S_RBRACE;
         S_MAX:    state_next = digit_last ? S_RBRACE : S_MAX;
         S_RBRACE: state_next = body_first(job_ff);
         S_BSL:    state_next = (job_ff.esc_class == ESC_BSL) ? S_BYTE : S_HEXX;
         S_HEXX:   state_next = S_HEXHI;
         S_HEXHI:  state_next = S_HEXLO;
         S_HEXLO:  state_next = job_ff.fin ? S_TSLASH : S_IDLE;
         S_BYTE:   state_next = job_ff.fin ? S_TSLASH : S_IDLE;
         S_TSLASH: state_next = S_TS;
         S_TS: begin
            if (job_ff.nocase) begin
               state_next = S_TI;
            end else begin
               state_next = job_ff.relative ? S_TR : S_TQUOTE;
            end
         end
         S_TI:     state_next = job_ff.relative ? S_TR : S_TQUOTE;
         S_TR:     state_next = S_TQUOTE;
         S_TQUOTE: state_next = S_IDLE;
         default:  state_next = S_IDLE;
      endcase
   end

   // Pick the character of the current state
   always_comb begin
      emit_data.status      = ST_OK;
      emit_data.end_of_text = 1'b0;
      case (state_ff)
         S_ERR: begin
            emit_data.out_char    = CH_NUL;
            emit_data.status      = job_ff.err;
            emit_data.end_of_text = 1'b1;
         end
         S_HQUOTE: emit_data.out_char = CH_QUOTE;
         S_HSLASH: emit_data.out_char = CH_SLASH;
         S_CARET:  emit_data.out_char = CH_CARET;
         S_DOT:    emit_data.out_char = CH_DOT;
         S_LBRACE: emit_data.out_char = CH_LBRACE;
         S_MIN:    emit_data.out_char = CH_ZERO + {4'd0, dstep.digit};
         S_COMMA:  emit_data.out_char = CH_COMMA;
         S_MAX:    emit_data.out_char = CH_ZERO + {4'd0, dstep.digit};
         S_RBRACE: emit_data.out_char = CH_RBRACE;
         S_BSL:    emit_data.out_char = CH_BSL;
         S_HEXX:   emit_data.out_char = CH_X;
         S_HEXHI:  emit_data.out_char = ctre_hex_char(job_ff.content_byte[7:4]);
         S_HEXLO:  emit_data.out_char = ctre_hex_char(job_ff.content_byte[3:0]);
         S_BYTE:   emit_data.out_char = job_ff.content_byte;
         S_TSLASH: emit_data.out_char = CH_SLASH;
         S_TS:     emit_data.out_char = CH_S;
         S_TI:     emit_data.out_char = CH_I;
         S_TR:     emit_data.out_char = CH_R;
         S_TQUOTE: begin
            emit_data.out_char    = CH_QUOTE;
            emit_data.end_of_text = 1'b1;
         end
         default:  emit_data.out_char = CH_NUL;
      endcase
   end

   // Drop leading zeros of a decimal number, keep the last digit
   assign emit = adv && (!in_digits || started_ff || dstep.digit != 4'd0 || digit_last);

   // Advance the sequencer, take the next job as the current one ends
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      job_pop    = 1'b0;
      dv_in      = dv_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      if (state_ff == S_IDLE) begin
         if (!job_empty) begin
            job_pop  = 1'b1;
            job_in   = head_job;
            state_in = job_first(head_job);
         end
      end else if (adv) begin
         if (state_next == S_IDLE && !job_empty) begin
            job_pop  = 1'b1;
            job_in   = head_job;
            state_in = job_first(head_job);
         end else begin
            state_in = state_next;
         end
         if (in_digits && !digit_last) begin
            pos_in     = pos_ff + 3'd1;
            dv_in      = dstep.rem;
            started_in = started_ff || (dstep.digit != 4'd0);
         end else if (state_next == S_MIN && state_ff != S_MIN) begin
            dv_in      = job_ff.min_skip;
            pos_in     = DIGIT_POS_FIRST;
            started_in = 1'b0;
         end else if (state_next == S_MAX && state_ff != S_MAX) begin
            dv_in      = job_ff.max_skip;
            pos_in     = DIGIT_POS_FIRST;
            started_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      dv_ff      <= dv_in;
      pos_ff     <= pos_in;
      started_ff <= started_in;
   end

   // Result queue toward the consumer
   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp_data  = out_ff[out_rd_ff];
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (emit && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !emit) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         out_wr_ff  <= emit ? !out_wr_ff : out_wr_ff;
         out_rd_ff  <= out_pop ? !out_rd_ff : out_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff[out_wr_ff] <= emit_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/content_to_regex_escaper.sv -----
// ----------------------------------------------------------------------------
// Content to regex escaper
// Turns pattern bytes into the characters of a quoted regex string.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake                       Carries
//   req_*        in         push, full                      ctre_req_type
//   rsp_*        out        empty, pop                      ctre_rsp_type
//   csr_*        in/out     psel, penable, pwrite, pready   option registers
//
// The back end emits one character per cycle, but for dropped leading zeros,
// while the result queue has room. A byte passes through, gets a backslash or
// becomes a hex escape. A pattern's first byte adds a header (each decimal
// number takes 5 digit steps), its last a trailer; an error yields one result.
// A 4-deep job queue lets the front end keep accepting while the back end
// stalls on a full 2-entry result queue. Reset empties both queues and idles.
// ----------------------------------------------------------------------------
`default_nettype none

module content_to_regex_escaper import ctre_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   input  wire ctre_req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   output ctre_rsp_type      rsp_data,
   input  wire logic         rsp_pop,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   ctre_cfg_type cfg_ff, cfg_in;
   logic         csr_write;
   logic [2:0]   reg_index;
   logic         job_push, job_full, job_pop, job_empty;
   ctre_job_type job_data, head_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   // Write the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_OPTION_FLAGS:   cfg_in.option_flags   = csr_pwdata[4:0];
            REG_OFFSET_VALUE:   cfg_in.offset_value   = csr_pwdata[15:0];
            REG_DEPTH_VALUE:    cfg_in.depth_value    = csr_pwdata[15:0];
            REG_DISTANCE_VALUE: cfg_in.distance_value = csr_pwdata[15:0];
            REG_WITHIN_VALUE:   cfg_in.within_value   = csr_pwdata[15:0];
            REG_PATTERN_LENGTH: cfg_in.pattern_length = csr_pwdata[12:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.option_flags   <= 5'd0;
         cfg_ff.offset_value   <= 16'hFFFF;
         cfg_ff.depth_value    <= 16'hFFFF;
         cfg_ff.distance_value <= 16'hFFFF;
         cfg_ff.within_value   <= 16'hFFFF;
         cfg_ff.pattern_length <= 13'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_index)
         REG_OPTION_FLAGS:   csr_prdata = {27'd0, cfg_ff.option_flags};
         REG_OFFSET_VALUE:   csr_prdata = {16'd0, cfg_ff.offset_value};
         REG_DEPTH_VALUE:    csr_prdata = {16'd0, cfg_ff.depth_value};
         REG_DISTANCE_VALUE: csr_prdata = {16'd0, cfg_ff.distance_value};
         REG_WITHIN_VALUE:   csr_prdata = {16'd0, cfg_ff.within_value};
         REG_PATTERN_LENGTH: csr_prdata = {19'd0, cfg_ff.pattern_length};
         default:            csr_prdata = 32'd0;
      endcase
   end

   ctre_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_push (job_push),
      .job_data (job_data),
      .job_full (job_full)
   );

   ctre_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_data),
      .full     (job_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   ctre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

// ----- hdl/ctre_checker.sv -----
// ----------------------------------------------------------------------------
// Regex escaper checker
// Port-level assertions on results and register readback.
// ----------------------------------------------------------------------------
`default_nettype none

`include "content_to_regex_escaper_defines.svh"

module ctre_checker import ctre_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_push,
   input wire ctre_req_type req_data,
   input wire logic         req_full,
   input wire logic         rsp_empty,
   input wire ctre_rsp_type rsp_data,
   input wire logic         rsp_pop,
   input wire logic         csr_psel,
   input wire logic         csr_penable,
   input wire logic         csr_pwrite,
   input wire logic [4:0]   csr_paddr,
   input wire logic [31:0]  csr_pwdata,
   input wire logic [31:0]  csr_prdata,
   input wire logic         csr_pready
);

   logic flags_write, flags_read;

   assign flags_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                        csr_paddr[4:2] == REG_OPTION_FLAGS;
   assign flags_read  = csr_psel && !csr_pwrite && csr_paddr[4:2] == REG_OPTION_FLAGS;

   // No result survives reset
   `CTRE_ASSERT_NXT_ALWAYS(a_reset_drains, reset, rsp_empty)

   // An error transaction closes the pattern and carries no character
   `CTRE_ASSERT_IMP(a_error_form, !rsp_empty && rsp_data.status != ST_OK, rsp_data.end_of_text && rsp_data.out_char == CH_NUL)

   // Only the closing transaction or an error may carry a non-ok status
   `CTRE_ASSERT_IMP(a_status_ok_mid, !rsp_empty && !rsp_data.end_of_text, rsp_data.status == ST_OK)

   // Hold a stalled result
   `CTRE_ASSERT_NXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

   // Read back the option flags just written
   `CTRE_ASSERT_IMP(a_flags_readback, $past(flags_write) && !$past(reset) && flags_read, csr_prdata[4:0] == $past(csr_pwdata[4:0]) && csr_prdata[31:5] == 27'd0)

endmodule

bind content_to_regex_escaper ctre_checker u_ctre_checker (.*);

`default_nettype wire
